// ===== hw/rtl/dense_layer_with_l1_row_norm_top_macros.svh =====
// assertion macros shared by the dense layer rtl
// expects clk and rst in the scope of each use
`ifndef DENSE_LAYER_WITH_L1_ROW_NORM_TOP_MACROS_SVH
`define DENSE_LAYER_WITH_L1_ROW_NORM_TOP_MACROS_SVH

// condition must hold at every edge out of reset
`define DLN_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define DLN_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/dlnorm_pkg.sv =====
// types and constants of the dense layer with l1 row normalization
// no dependencies
package dlnorm_pkg;

  localparam int W_W     = 16;
  localparam int PROD_W  = 32;
  localparam int ACC_W   = 40;
  localparam int NUM_W   = 30;
  localparam int DEN_W   = 20;
  localparam int MAG_W   = 17;
  localparam int FRAC_W  = 14;
  localparam int CFG_W   = 5;
  localparam int ONE_Q14 = 16384;
  localparam int MAX_OUT = 16;

  localparam logic REG_NEURONS = 1'b0;
  localparam logic REG_INPUTS  = 1'b1;

  typedef enum logic [1:0] {
    KIND_WEIGHT  = 2'd0,
    KIND_INPUT   = 2'd1,
    KIND_FORWARD = 2'd2,
    KIND_NORM    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [15:0] value;
  } cmd_t;

  typedef struct packed {
    logic [3:0]         neuron;
    logic signed [39:0] activation;
    logic               last;
  } res_t;

endpackage

// ===== hw/rtl/dlnorm_ram.sv =====
// generic single write, single read ram with registered read data
// depends on nothing
module dlnorm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/dlnorm_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on dlnorm_pkg
module dlnorm_div
  import dlnorm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [NUM_W-1:0] q;
  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [DEN_W:0]   diff;

  always_comb begin
    rem_sh = {rem, q[NUM_W-1]};
    ge     = rem_sh >= {1'b0, dvs};
    diff   = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvs  <= den;
        q    <= num;
      end else if (busy) begin
        // remainder stays below the divisor, so the top bit drops
        rem <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        q   <= {q[NUM_W-2:0], ge};
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  assign quo = q;

endmodule

// ===== hw/rtl/dense_layer_with_l1_row_norm_top.sv =====
// dense layer: weight and input memories, forward pass and l1 row normalization
// load items write straight into memory; a forward pass per row does weight read, multiply and accumulate
// normalize: per row, a sum of weight magnitudes, then each weight of a
// row that is scaled goes through the 30-step divider
// after reset a clearing pass over all NEURONS*INPUTS addresses zeroes both memories
// depends on dlnorm_pkg, dlnorm_ram, dlnorm_div and the macros header
`include "dense_layer_with_l1_row_norm_top_macros.svh"

module dense_layer_with_l1_row_norm_top
  import dlnorm_pkg::*;
#(
  parameter int NEURONS = 16,
  parameter int INPUTS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  cmd_t        cmd,
  output logic        res_valid,
  input  logic        res_stall,
  output res_t        res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int WDEPTH = NEURONS * INPUTS;
  localparam int WA     = $clog2(WDEPTH > 1 ? WDEPTH : 2);
  localparam int XA     = $clog2(INPUTS > 1 ? INPUTS : 2);
  localparam int RW     = $clog2(NEURONS + 1);
  localparam int CW     = $clog2(INPUTS + 1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_FRUN, ST_FOUT, ST_NSUM, ST_NCHK, ST_NRD, ST_NWAIT, ST_NDIV
  } state_t;

  state_t state;

  // configuration
  logic [CFG_W-1:0] act_neurons;
  logic [CFG_W-1:0] act_inputs;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_INPUTS) ? {27'b0, act_inputs} : {27'b0, act_neurons};

  always_ff @(posedge clk) begin
    if (rst) begin
      act_neurons <= CFG_W'(16);
      act_inputs  <= CFG_W'(16);
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_NEURONS) begin
        act_neurons <= pwdata[CFG_W-1:0];
      end else begin
        act_inputs <= pwdata[CFG_W-1:0];
      end
    end
  end

  logic [RW-1:0] n_eff;
  logic [RW-1:0] n_fwd;
  logic [CW-1:0] m_eff;

  always_comb begin
    n_eff = (int'(act_neurons) > NEURONS) ? RW'(NEURONS) : RW'(act_neurons);
    n_fwd = (int'(n_eff) > MAX_OUT) ? RW'(MAX_OUT) : n_eff;
    m_eff = (int'(act_inputs) > INPUTS) ? CW'(INPUTS) : CW'(act_inputs);
  end

  // walk registers
  logic [WA-1:0]           clr_addr;
  logic [RW-1:0]           i;
  logic [RW-1:0]           rows_lim;
  logic [CW-1:0]           j;
  logic [CW-1:0]           cols_lim;
  logic [WA-1:0]           base;
  logic                    d1;
  logic                    d2;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic [DEN_W-1:0]        sum;
  logic [MAG_W-1:0]        wmag;
  logic                    wneg;
  logic                    div_start;
  logic                    div_done;
  logic [NUM_W-1:0]        div_num;
  logic [NUM_W-1:0]        div_quo;

  // memories
  logic          w_we;
  logic [WA-1:0] w_waddr;
  logic [W_W-1:0] w_wdata;
  logic [WA-1:0] w_raddr;
  logic [W_W-1:0] w_rdata;
  logic          x_we;
  logic [XA-1:0] x_waddr;
  logic [W_W-1:0] x_wdata;
  logic [W_W-1:0] x_rdata;

  logic           accept;
  logic           issue;
  logic [WA-1:0]  cur_addr;
  logic [MAG_W-1:0] rd_mag;
  logic [W_W-1:0] scaled;
  logic           last_row;
  logic           last_col;
  logic           res_free;

  assign cmd_stall = (state != ST_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign issue     = (state == ST_FRUN || state == ST_NSUM) && (j < cols_lim);
  assign cur_addr  = base + WA'(j);
  assign w_raddr   = cur_addr;
  assign rd_mag    = w_rdata[W_W-1] ? MAG_W'(-$signed({w_rdata[W_W-1], w_rdata}))
                                    : {1'b0, w_rdata};
  assign scaled    = wneg ? W_W'(-$signed(div_quo[W_W-1:0])) : div_quo[W_W-1:0];
  assign last_row  = (i == rows_lim - 1'b1);
  assign last_col  = (j == cols_lim - 1'b1);
  assign res_free  = !res_valid || !res_stall;
  // magnitude is at most 32768, so the top bit of wmag is always clear
  assign div_num   = {wmag[NUM_W-FRAC_W-1:0], {FRAC_W{1'b0}}};

  always_comb begin
    w_we    = 1'b0;
    w_waddr = cur_addr;
    w_wdata = scaled;
    x_we    = 1'b0;
    x_waddr = clr_addr[XA-1:0];
    x_wdata = '0;
    case (state)
      ST_CLEAR: begin
        w_we    = 1'b1;
        w_waddr = clr_addr;
        w_wdata = '0;
        x_we    = (int'(clr_addr) < INPUTS);
      end
      ST_IDLE: begin
        if (accept && cmd.kind == KIND_WEIGHT && int'(cmd.row) < NEURONS
            && int'(cmd.col) < INPUTS) begin
          w_we    = 1'b1;
          w_waddr = WA'(int'(cmd.row) * INPUTS + int'(cmd.col));
          w_wdata = cmd.value;
        end
        if (accept && cmd.kind == KIND_INPUT && int'(cmd.col) < INPUTS) begin
          x_we    = 1'b1;
          x_waddr = XA'(cmd.col);
          x_wdata = cmd.value;
        end
      end
      ST_NDIV: begin
        w_we = div_done;
      end
      default: begin
      end
    endcase
  end

  dlnorm_ram #(.WIDTH(W_W), .DEPTH(WDEPTH)) u_wmem (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  dlnorm_ram #(.WIDTH(W_W), .DEPTH(INPUTS)) u_xmem (
    .clk   (clk),
    .we    (x_we),
    .waddr (x_waddr),
    .wdata (x_wdata),
    .raddr (j[XA-1:0]),
    .rdata (x_rdata)
  );

  dlnorm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (sum),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      res_valid <= 1'b0;
      d1        <= 1'b0;
      d2        <= 1'b0;
      div_start <= 1'b0;
    end else begin
      d1        <= issue;
      d2        <= d1;
      div_start <= 1'b0;
      if (d1) begin
        prod <= $signed(w_rdata) * $signed(x_rdata);
      end
      // the output state reloads the result register itself
      if (res_valid && !res_stall && state != ST_FOUT) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == WA'(WDEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          i        <= '0;
          j        <= '0;
          base     <= '0;
          acc      <= '0;
          sum      <= '0;
          cols_lim <= m_eff;
          if (accept && cmd.kind == KIND_FORWARD) begin
            rows_lim <= n_fwd;
            if (n_fwd != '0) begin
              state <= ST_FRUN;
            end
          end else if (accept && cmd.kind == KIND_NORM) begin
            rows_lim <= n_eff;
            if (n_eff != '0) begin
              state <= ST_NSUM;
            end
          end
        end
        ST_FRUN: begin
          if (issue) begin
            j <= j + 1'b1;
          end
          if (d2) begin
            acc <= acc + ACC_W'(prod);
          end
          if (!issue && !d1 && !d2) begin
            state <= ST_FOUT;
          end
        end
        ST_FOUT: begin
          if (res_free) begin
            res_valid      <= 1'b1;
            res.neuron     <= 4'(i);
            res.activation <= acc;
            res.last       <= last_row;
            if (last_row) begin
              state <= ST_IDLE;
            end else begin
              i     <= i + 1'b1;
              base  <= base + WA'(INPUTS);
              j     <= '0;
              acc   <= '0;
              state <= ST_FRUN;
            end
          end
        end
        ST_NSUM: begin
          if (issue) begin
            j <= j + 1'b1;
          end
          if (d1) begin
            sum <= sum + DEN_W'(rd_mag);
          end
          if (!issue && !d1) begin
            state <= ST_NCHK;
          end
        end
        ST_NCHK: begin
          j <= '0;
          if (int'(sum) > ONE_Q14) begin
            state <= ST_NRD;
          end else if (last_row) begin
            state <= ST_IDLE;
          end else begin
            i     <= i + 1'b1;
            base  <= base + WA'(INPUTS);
            sum   <= '0;
            state <= ST_NSUM;
          end
        end
        ST_NRD: begin
          state <= ST_NWAIT;
        end
        ST_NWAIT: begin
          wmag      <= rd_mag;
          wneg      <= w_rdata[W_W-1];
          div_start <= 1'b1;
          state     <= ST_NDIV;
        end
        ST_NDIV: begin
          if (div_done) begin
            if (!last_col) begin
              j     <= j + 1'b1;
              state <= ST_NRD;
            end else if (last_row) begin
              state <= ST_IDLE;
            end else begin
              i     <= i + 1'b1;
              j     <= '0;
              base  <= base + WA'(INPUTS);
              sum   <= '0;
              state <= ST_NSUM;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `DLN_ASSERT_IMPLIES(a_clear_blocks, state == ST_CLEAR, cmd_stall, "item taken during clear")
  `DLN_ASSERT_IMPLIES(a_div_in_norm, div_done, state == ST_NDIV, "divider done outside scaling")
  `DLN_ASSERT_IMPLIES(a_wr_source, w_we && state != ST_CLEAR && state != ST_IDLE, state == ST_NDIV && div_done, "weight write from wrong state")
  `DLN_ASSERT_IMPLIES(a_res_load, $rose(res_valid), $past(state) == ST_FOUT, "result loaded outside output state")

endmodule
